### src/mta_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mta_pkg
// Shared types and constants of the 4x4 transform accumulator: control of the
// shared multiply-accumulate unit, angle reduction and cordic constants.
// ----------------------------------------------------------------------------
package mta_pkg;

  typedef struct packed {
    logic init;  // load accumulator with init value
    logic mul;   // register a product
    logic add;   // add registered product to accumulator
    logic rnd;   // round the product to fixed point before adding
  } mac_ctl_t;

  localparam int unsigned CORDIC_ITERS = 30;
  localparam logic signed [33:0] CORDIC_X0 = 34'sh026DD3B6A;
  localparam logic [31:0] RED_MULT = 32'hA2F9836E;
  localparam logic signed [33:0] QUARTER_TURN = 34'sh040000000;
  localparam logic signed [33:0] HALF_TURN = 34'sh080000000;

  // arctangent of 2^-i in 2^-32 turns
  function automatic logic [31:0] atan_turns(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

### src/mta_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mta_mac
// Shared 33x33 signed multiplier with registered product and a 64-bit
// accumulator; products are added raw or rounded half up to fixed point.
// ----------------------------------------------------------------------------
module mta_mac import mta_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  mac_ctl_t           ctl,
  input  logic [63:0]        init_val,
  input  logic signed [32:0] op_a,
  input  logic signed [32:0] op_b,
  output logic [63:0]        acc
);

  localparam logic signed [65:0] HALF = 66'sd1 <<< (FRAC_BITS - 1);

  logic signed [65:0] prod_r;
  logic signed [65:0] rnd_sum;
  logic [63:0]        acc_r;
  logic [63:0]        term;

  assign rnd_sum = prod_r + HALF;
  assign term    = ctl.rnd ? 64'(rnd_sum >>> FRAC_BITS) : prod_r[63:0];
  assign acc     = acc_r;

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      prod_r <= op_a * op_b;
    end
    if (ctl.init) begin
      acc_r <= init_val;
    end else if (ctl.add) begin
      acc_r <= acc_r + term;
    end
  end

endmodule

### src/matrix4_transform_accumulator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix4_transform_accumulator_unit
// 4x4 fixed point transform matrix with identity, scale, translate, rotate,
// operand load, multiply and read out commands on one shared multiplier.
// ----------------------------------------------------------------------------
// identity, operand load and unused codes return straight to idle; scale, translate,
// multiply and rotate run on the multiplier. rotate: sum of squares, 32-step root,
// three 64-step divides, 30 cordic steps, the multiplier products, then commit;
// a zero axis ends after the sum of squares. divides and root go 1 bit/cycle.
// read out gives 16 results, one per cycle unstalled.
// reset: matrix back to identity; the operand matrix is not cleared.
module matrix4_transform_accumulator_unit import mta_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_command,
  input  logic signed [31:0] in_angle,
  input  logic signed [31:0] in_vx,
  input  logic signed [31:0] in_vy,
  input  logic signed [31:0] in_vz,
  input  logic [3:0]         in_elem_index,
  input  logic signed [31:0] in_elem_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         out_index,
  output logic signed [31:0] out_value,
  output logic               out_last
);

  localparam logic [2:0] CMD_IDENT = 3'd0;
  localparam logic [2:0] CMD_SCALE = 3'd1;
  localparam logic [2:0] CMD_TRANS = 3'd2;
  localparam logic [2:0] CMD_ROT   = 3'd3;
  localparam logic [2:0] CMD_LOAD  = 3'd4;
  localparam logic [2:0] CMD_MUL   = 3'd5;
  localparam logic [2:0] CMD_READ  = 3'd6;

  localparam int CS = 30 - FRAC_BITS;
  localparam logic signed [33:0] CHALF = (34'sd1 <<< CS) >>> 1;
  localparam logic signed [31:0] ONE = 32'(64'sd1 <<< FRAC_BITS);
  localparam logic signed [32:0] ONE33 = 33'(64'sd1 <<< FRAC_BITS);

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_INIT   = 10'b0000000010,
    ST_MUL    = 10'b0000000100,
    ST_ADD    = 10'b0000001000,
    ST_WB     = 10'b0000010000,
    ST_SQRT   = 10'b0000100000,
    ST_DIV    = 10'b0001000000,
    ST_CORDIC = 10'b0010000000,
    ST_COMMIT = 10'b0100000000,
    ST_OUT    = 10'b1000000000
  } state_t;

  typedef enum logic [2:0] {
    J_SCALE, J_TRANS, J_MMUL, J_RMUL, J_SQ, J_ANG, J_PROD, J_REL
  } job_t;

  state_t state_r, state_nxt;
  job_t   job_r;

  logic signed [31:0] m_r   [16];
  logic signed [31:0] p_r   [16];
  logic signed [31:0] t_r   [16];
  logic signed [31:0] rot_r [16];
  logic signed [31:0] tp_r  [9];
  logic signed [31:0] u_r   [3];
  logic signed [31:0] cos_r, sin_r;
  logic signed [31:0] vx_r, vy_r, vz_r, angle_r;

  logic [3:0] e_r, oc_r;
  logic [1:0] k_r, d_r;
  logic [5:0] cnt_r;

  logic [63:0] sq_n_r, sq_res_r, sq_bit_r;
  logic [32:0] div_rem_r;
  logic [63:0] div_num_r;
  logic [31:0] div_q_r;
  logic signed [33:0] cx_r, cy_r, cz_r;
  logic flip_r;

  logic               out_valid_r, out_last_r;
  logic [3:0]         out_index_r;
  logic signed [31:0] out_value_r;

  // shared unit
  mac_ctl_t           mac_ctl;
  logic [63:0]        init_val, acc;
  logic signed [32:0] op_a, op_b;
  logic signed [63:0] acc_s;

  logic [3:0]         m_idx, rel_dst, elast;
  logic [1:0]         nterms_m1;
  logic signed [31:0] m_rd, v_k, v_row;
  logic signed [32:0] omc;
  logic               accept, out_load;

  // root, divide, reduction, cordic
  logic [63:0]        sq_sum, sq_res_nxt;
  logic               sq_ge;
  logic [31:0]        mag, mag_src;
  logic [32:0]        rem_sh, rem_nxt;
  logic               div_ge;
  logic [31:0]        q_nxt;
  logic signed [31:0] v_d, v_dsel;
  logic [1:0]         dsel;
  logic [31:0]        av_sel;
  logic [63:0]        div_num_init;
  logic [31:0]        ph, phn;
  logic signed [33:0] z0, red_z;
  logic               red_flip;
  logic signed [33:0] cxs, cys, cx_nxt, cy_nxt, cz_nxt, at, fx, fy;
  logic signed [33:0] cos_full, sin_full;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_load  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_index = out_index_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;
  assign acc_s     = signed'(acc);

  assign mac_ctl.init = (state_r == ST_INIT);
  assign mac_ctl.mul  = (state_r == ST_MUL);
  assign mac_ctl.add  = (state_r == ST_ADD);
  assign mac_ctl.rnd  = !(job_r == J_SQ || job_r == J_ANG);

  mta_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk      (clk),
    .ctl      (mac_ctl),
    .init_val (init_val),
    .op_a     (op_a),
    .op_b     (op_b),
    .acc      (acc)
  );

  assign m_rd  = m_r[m_idx];
  assign omc   = ONE33 - {cos_r[31], cos_r};
  assign v_k   = (k_r == 2'd0) ? vx_r : (k_r == 2'd1) ? vy_r : vz_r;
  assign v_row = (e_r[3:2] == 2'd0) ? vx_r : (e_r[3:2] == 2'd1) ? vy_r : vz_r;

  always_comb begin
    case (job_r)
      J_SCALE: begin elast = 4'd11; nterms_m1 = 2'd0; end
      J_TRANS: begin elast = 4'd3;  nterms_m1 = 2'd2; end
      J_MMUL:  begin elast = 4'd15; nterms_m1 = 2'd3; end
      J_RMUL:  begin elast = 4'd15; nterms_m1 = 2'd3; end
      J_SQ:    begin elast = 4'd0;  nterms_m1 = 2'd2; end
      J_ANG:   begin elast = 4'd0;  nterms_m1 = 2'd0; end
      J_PROD:  begin elast = 4'd8;  nterms_m1 = 2'd0; end
      J_REL:   begin elast = 4'd8;  nterms_m1 = 2'd0; end
      default: begin elast = 4'd0;  nterms_m1 = 2'd0; end
    endcase
  end

  // operand selection for the shared unit
  always_comb begin
    m_idx    = e_r;
    op_a     = '0;
    op_b     = '0;
    init_val = '0;
    rel_dst  = 4'd0;
    if (state_r == ST_OUT) begin
      m_idx = oc_r;
    end else begin
      case (job_r)
        J_SCALE: begin
          op_a = {m_rd[31], m_rd};
          op_b = {v_row[31], v_row};
        end
        J_TRANS: begin
          m_idx    = (state_r == ST_INIT) ? {2'b11, e_r[1:0]} : {k_r, e_r[1:0]};
          init_val = 64'(m_rd);
          op_a     = {m_rd[31], m_rd};
          op_b     = {v_k[31], v_k};
        end
        J_MMUL: begin
          m_idx = {e_r[3:2], k_r};
          op_a  = {m_rd[31], m_rd};
          op_b  = 33'(p_r[{k_r, e_r[1:0]}]);
        end
        J_RMUL: begin
          m_idx = {k_r, e_r[1:0]};
          op_a  = 33'(rot_r[{e_r[3:2], k_r}]);
          op_b  = {m_rd[31], m_rd};
        end
        J_SQ: begin
          op_a = {v_k[31], v_k};
          op_b = {v_k[31], v_k};
        end
        J_ANG: begin
          op_a = {1'b0, angle_r[31] ? 32'(-angle_r) : angle_r};
          op_b = {1'b0, RED_MULT};
        end
        J_PROD: begin
          case (e_r)
            4'd0, 4'd3, 4'd6: op_a = 33'(u_r[0]);
            4'd1, 4'd4, 4'd7: op_a = 33'(u_r[1]);
            default:          op_a = 33'(u_r[2]);
          endcase
          case (e_r)
            4'd0, 4'd5: op_b = 33'(u_r[0]);
            4'd1, 4'd3: op_b = 33'(u_r[1]);
            4'd2, 4'd4: op_b = 33'(u_r[2]);
            default:    op_b = 33'(sin_r);
          endcase
        end
        J_REL: begin
          op_a = omc;
          // products: xx yy zz xy yz zx xs ys zs
          case (e_r)
            4'd0: begin rel_dst = 4'd0;  op_b = 33'(tp_r[0]); init_val = 64'(cos_r); end
            4'd1: begin rel_dst = 4'd1;  op_b = 33'(tp_r[3]); init_val = -64'(tp_r[8]); end
            4'd2: begin rel_dst = 4'd2;  op_b = 33'(tp_r[5]); init_val = 64'(tp_r[7]); end
            4'd3: begin rel_dst = 4'd4;  op_b = 33'(tp_r[3]); init_val = 64'(tp_r[8]); end
            4'd4: begin rel_dst = 4'd5;  op_b = 33'(tp_r[1]); init_val = 64'(cos_r); end
            4'd5: begin rel_dst = 4'd6;  op_b = 33'(tp_r[4]); init_val = -64'(tp_r[6]); end
            4'd6: begin rel_dst = 4'd8;  op_b = 33'(tp_r[5]); init_val = -64'(tp_r[7]); end
            4'd7: begin rel_dst = 4'd9;  op_b = 33'(tp_r[4]); init_val = 64'(tp_r[6]); end
            default: begin
              rel_dst = 4'd10; op_b = 33'(tp_r[2]); init_val = 64'(cos_r);
            end
          endcase
        end
        default: begin
          op_a = '0;
        end
      endcase
    end
  end

  // integer root, one result bit per cycle
  assign sq_sum     = sq_res_r + sq_bit_r;
  assign sq_ge      = sq_n_r >= sq_sum;
  assign sq_res_nxt = sq_ge ? ((sq_res_r >> 1) + sq_bit_r) : (sq_res_r >> 1);
  assign mag        = sq_res_r[31:0];
  assign mag_src    = (state_r == ST_SQRT) ? sq_res_nxt[31:0] : mag;

  // restoring divide, one quotient bit per cycle
  assign rem_sh  = {div_rem_r[31:0], div_num_r[63]};
  assign div_ge  = rem_sh >= {1'b0, mag};
  assign rem_nxt = div_ge ? (rem_sh - {1'b0, mag}) : rem_sh;
  assign q_nxt   = {div_q_r[30:0], div_ge};
  assign v_d     = (d_r == 2'd0) ? vx_r : (d_r == 2'd1) ? vy_r : vz_r;
  assign dsel    = (state_r == ST_SQRT) ? 2'd0 : d_r + 2'd1;
  assign v_dsel  = (dsel == 2'd0) ? vx_r : (dsel == 2'd1) ? vy_r : vz_r;
  assign av_sel  = v_dsel[31] ? 32'(-v_dsel) : v_dsel;
  assign div_num_init = ({32'd0, av_sel} << FRAC_BITS) + {33'd0, mag_src[31:1]};

  // angle reduction to within a quarter turn
  always_comb begin
    ph       = acc[FRAC_BITS + 2 +: 32];
    phn      = angle_r[31] ? (32'd0 - ph) : ph;
    z0       = {{2{phn[31]}}, phn};
    red_z    = z0;
    red_flip = 1'b0;
    if (z0 > QUARTER_TURN) begin
      red_z    = z0 - HALF_TURN;
      red_flip = 1'b1;
    end else if (z0 < -QUARTER_TURN) begin
      red_z    = z0 + HALF_TURN;
      red_flip = 1'b1;
    end
  end

  // cordic rotation step
  always_comb begin
    cxs = cx_r >>> cnt_r[4:0];
    cys = cy_r >>> cnt_r[4:0];
    at  = {2'b00, atan_turns(cnt_r[4:0])};
    if (!cz_r[33]) begin
      cx_nxt = cx_r - cys;
      cy_nxt = cy_r + cxs;
      cz_nxt = cz_r - at;
    end else begin
      cx_nxt = cx_r + cys;
      cy_nxt = cy_r - cxs;
      cz_nxt = cz_r + at;
    end
    fx       = flip_r ? -cx_nxt : cx_nxt;
    fy       = flip_r ? -cy_nxt : cy_nxt;
    cos_full = (fx + CHALF) >>> CS;
    sin_full = (fy + CHALF) >>> CS;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_command)
            CMD_SCALE, CMD_TRANS, CMD_ROT, CMD_MUL: state_nxt = ST_INIT;
            CMD_READ: state_nxt = ST_OUT;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_INIT: state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_ADD;
      ST_ADD:  state_nxt = (k_r == nterms_m1) ? ST_WB : ST_MUL;
      ST_WB: begin
        if (e_r != elast) begin
          state_nxt = ST_INIT;
        end else begin
          case (job_r)
            J_MMUL, J_RMUL: state_nxt = ST_COMMIT;
            J_SQ:           state_nxt = (acc == 64'd0) ? ST_IDLE : ST_SQRT;
            J_ANG:          state_nxt = ST_CORDIC;
            J_PROD, J_REL:  state_nxt = ST_INIT;
            default:        state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SQRT:   state_nxt = (cnt_r == 6'd31) ? ST_DIV : ST_SQRT;
      ST_DIV:    state_nxt = (cnt_r == 6'd63 && d_r == 2'd2) ? ST_INIT : ST_DIV;
      ST_CORDIC: begin
        state_nxt = (cnt_r == 6'(CORDIC_ITERS - 1)) ? ST_INIT : ST_CORDIC;
      end
      ST_COMMIT: state_nxt = ST_IDLE;
      ST_OUT:    state_nxt = (out_load && oc_r == 4'd15) ? ST_IDLE : ST_OUT;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        m_r[i] <= (i / 4 == i % 4) ? ONE : 32'sd0;
      end
    end else begin
      state_r <= state_nxt;

      if (state_r == ST_OUT && out_load) begin
        out_valid_r <= 1'b1;
        out_index_r <= oc_r;
        out_value_r <= m_rd;
        out_last_r  <= (oc_r == 4'd15);
        oc_r        <= oc_r + 4'd1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            vx_r    <= in_vx;
            vy_r    <= in_vy;
            vz_r    <= in_vz;
            angle_r <= in_angle;
            e_r     <= 4'd0;
            k_r     <= 2'd0;
            oc_r    <= 4'd0;
            case (in_command)
              CMD_IDENT: begin
                for (int i = 0; i < 16; i++) begin
                  m_r[i] <= (i / 4 == i % 4) ? ONE : 32'sd0;
                end
              end
              CMD_SCALE: job_r <= J_SCALE;
              CMD_TRANS: job_r <= J_TRANS;
              CMD_ROT: begin
                job_r     <= J_SQ;
                rot_r[3]  <= 32'sd0;
                rot_r[7]  <= 32'sd0;
                rot_r[11] <= 32'sd0;
                rot_r[12] <= 32'sd0;
                rot_r[13] <= 32'sd0;
                rot_r[14] <= 32'sd0;
                rot_r[15] <= ONE;
              end
              CMD_LOAD:  p_r[in_elem_index] <= in_elem_value;
              CMD_MUL:   job_r <= J_MMUL;
              default:   job_r <= job_r;
            endcase
          end
        end
        ST_INIT: k_r <= 2'd0;
        ST_ADD: begin
          if (k_r != nterms_m1) begin
            k_r <= k_r + 2'd1;
          end
        end
        ST_WB: begin
          e_r <= (e_r == elast) ? 4'd0 : e_r + 4'd1;
          case (job_r)
            J_SCALE: m_r[e_r] <= sat32(acc_s);
            J_TRANS: m_r[{2'b11, e_r[1:0]}] <= sat32(acc_s);
            J_MMUL, J_RMUL: t_r[e_r] <= sat32(acc_s);
            J_SQ: begin
              sq_n_r   <= acc;
              sq_res_r <= 64'd0;
              sq_bit_r <= 64'd1 << 62;
              cnt_r    <= 6'd0;
            end
            J_ANG: begin
              cx_r   <= CORDIC_X0;
              cy_r   <= 34'sd0;
              cz_r   <= red_z;
              flip_r <= red_flip;
              cnt_r  <= 6'd0;
            end
            J_PROD: begin
              tp_r[e_r] <= sat32(acc_s);
              if (e_r == elast) begin
                job_r <= J_REL;
              end
            end
            J_REL: begin
              rot_r[rel_dst] <= sat32(acc_s);
              if (e_r == elast) begin
                job_r <= J_RMUL;
              end
            end
            default: job_r <= job_r;
          endcase
        end
        ST_SQRT: begin
          sq_n_r   <= sq_ge ? (sq_n_r - sq_sum) : sq_n_r;
          sq_res_r <= sq_res_nxt;
          sq_bit_r <= sq_bit_r >> 2;
          cnt_r    <= cnt_r + 6'd1;
          if (cnt_r == 6'd31) begin
            cnt_r     <= 6'd0;
            d_r       <= 2'd0;
            div_rem_r <= 33'd0;
            div_q_r   <= 32'd0;
            div_num_r <= div_num_init;
          end
        end
        ST_DIV: begin
          div_rem_r <= rem_nxt;
          div_q_r   <= q_nxt;
          div_num_r <= div_num_r << 1;
          cnt_r     <= cnt_r + 6'd1;
          if (cnt_r == 6'd63) begin
            u_r[d_r] <= v_d[31] ? 32'(-q_nxt) : q_nxt;
            if (d_r == 2'd2) begin
              job_r <= J_ANG;
              e_r   <= 4'd0;
            end else begin
              d_r       <= d_r + 2'd1;
              div_rem_r <= 33'd0;
              div_q_r   <= 32'd0;
              div_num_r <= div_num_init;
            end
          end
        end
        ST_CORDIC: begin
          cx_r  <= cx_nxt;
          cy_r  <= cy_nxt;
          cz_r  <= cz_nxt;
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'(CORDIC_ITERS - 1)) begin
            cos_r <= cos_full[31:0];
            sin_r <= sin_full[31:0];
            job_r <= J_PROD;
            e_r   <= 4'd0;
          end
        end
        ST_COMMIT: begin
          for (int i = 0; i < 16; i++) begin
            m_r[i] <= t_r[i];
          end
        end
        default: begin
          cnt_r <= cnt_r;
        end
      endcase
    end
  end

  // last flag marks exactly the final element of a read out
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_last_r == (out_index_r == 4'd15)))
    else $error("last flag does not match element index");

  // read out elements come in consecutive order
  a_out_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && !out_last_r) |=>
      (out_valid_r && out_index_r == $past(out_index_r) + 4'd1))
    else $error("read out element skipped");

  // a divide only starts after a nonzero axis length
  a_div_mag: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (mag != 32'd0))
    else $error("divide by zero axis length");

  // read request moves straight to read out
  a_read_go: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_command == CMD_READ) |=> (state_r == ST_OUT))
    else $error("read request not started");

endmodule
